>>> rtl/ulmwd_pkg.sv
// ----------------------------------------------------------------------------
// ulmwd_pkg
// Shared types and constants of the UART LED-matrix write decoder: port
// payloads, the queued operation between front and back, register indexes.
// ----------------------------------------------------------------------------
package ulmwd_pkg;

  // Accumulator width and queue depth defaults
  localparam int SumWidthDefault  = 12;
  localparam int FifoDepthDefault = 4;

  // Channel layout: C1..C12 then D1..D8
  localparam int NumC  = 12;
  localparam int NumD  = 8;
  localparam int NumCh = NumC + NumD;
  localparam int ChW   = $clog2(NumCh);

  // Duty scaling: width * 10000 / 1023
  localparam int DutyScale = 10000;

  // Configuration register indexes
  typedef enum logic {
    CFG_DEV_C = 1'b0,
    CFG_DEV_D = 1'b1
  } cfg_index_t;

  localparam logic [7:0] DevCReset = 8'd32;
  localparam logic [7:0] DevDReset = 8'd97;

  // Input beat
  typedef struct packed {
    logic [7:0] bus_byte;
    logic       frame_end;
  } in_item_t;

  // Output beat
  typedef struct packed {
    logic [4:0]  channel;
    logic [15:0] duty;
    logic        last_channel;
  } out_item_t;

  // Classified byte handed from front to back
  typedef struct packed {
    logic       is_data;
    logic       hit_c;
    logic       hit_d;
    logic [7:0] register;
    logic [7:0] data;
    logic       frame_end;
  } op_t;

endpackage

>>> rtl/uart_led_matrix_write_decoder_unit.sv
// ----------------------------------------------------------------------------
// uart_led_matrix_write_decoder_unit
// Top level: parser front end, operation queue, accumulator and duty back end.
// ----------------------------------------------------------------------------
// The block takes one bus byte per cycle as long as its operation queue
// (FIFO_DEPTH entries) has room. A byte marked frame end produces twenty duty
// beats, channels 0 to 19 in order, one per cycle when the output is taken,
// the first passing through the queue, the snapshot bank and channel counter,
// the multiply stage and the divide-and-output stage. The accumulators are
// copied to a snapshot bank and cleared at frame end, so bytes of the next
// frame keep flowing during emission; a further frame end waits in the
// queue until all twenty channels of the previous frame have been issued.
// Device addresses are written through cfg_we/cfg_index/cfg_wdata; the
// user must write them only while the block is idle, as the block itself
// does not enforce it.
module uart_led_matrix_write_decoder_unit
  import ulmwd_pkg::*;
#(
  parameter int SUM_WIDTH  = SumWidthDefault,
  parameter int FIFO_DEPTH = FifoDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  cfg_index_t cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  in_item_t   byte_item,
  output logic       duty_valid,
  input  logic       duty_ready,
  output out_item_t  duty_item
);

  logic push;
  op_t  push_op;
  op_t  head_op;
  logic fifo_full;
  logic fifo_empty;
  logic pop;
  logic accept;

  // Accept a byte beat while the queue has room
  assign byte_ready = !fifo_full;
  assign accept     = byte_valid && byte_ready;

  ulmwd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (byte_item),
    .push      (push),
    .push_op   (push_op)
  );

  ulmwd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  ulmwd_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_op   (head_op),
    .empty     (fifo_empty),
    .pop       (pop),
    .out_valid (duty_valid),
    .out_ready (duty_ready),
    .out_item  (duty_item)
  );

`ifndef SYNTH
  // The queue is never written while full
  assert property (@(posedge clk) disable iff (rst) push |-> !fifo_full)
    else $error("operation pushed into full queue");

  // The back end never takes from an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> !fifo_empty)
    else $error("operation popped from empty queue");

  // The last beat of a frame always carries the highest channel
  assert property (@(posedge clk) disable iff (rst)
    (duty_valid && duty_item.last_channel) |-> (duty_item.channel == 5'(NumCh - 1)))
    else $error("last_channel on wrong channel");
`endif

endmodule

>>> rtl/ulmwd_fifo.sv
// ----------------------------------------------------------------------------
// ulmwd_fifo
// Small queue of classified operations between the parser and the
// accumulator/emitter back end. DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module ulmwd_fifo
  import ulmwd_pkg::*;
#(
  parameter int DEPTH = FifoDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head_op,
  output logic full,
  output logic empty
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  op_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign head_op = mem[rd_ptr];

  // Store incoming operation
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (!push && pop) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/ulmwd_front.sv
// ----------------------------------------------------------------------------
// ulmwd_front
// Bus parser: holds the device address registers, walks the command framing
// one byte per beat and queues data bytes and frame ends for the back end.
// ----------------------------------------------------------------------------
module ulmwd_front
  import ulmwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  cfg_index_t cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       accept,
  input  in_item_t   item,
  output logic       push,
  output op_t        push_op
);

  // Write commands and their data lengths, read commands
  localparam logic [7:0] CmdW1  = 8'h87;
  localparam logic [7:0] CmdW2  = 8'h99;
  localparam logic [7:0] CmdW3  = 8'h1E;
  localparam logic [7:0] CmdW4  = 8'hAA;
  localparam logic [7:0] CmdW12 = 8'h2D;
  localparam logic [7:0] CmdW16 = 8'h33;
  localparam logic [7:0] CmdW32 = 8'hB4;
  localparam logic [7:0] CmdR0  = 8'h4B;
  localparam logic [7:0] CmdR1  = 8'hCC;
  localparam logic [7:0] CmdR2  = 8'hD2;
  localparam logic [7:0] CmdR3  = 8'h55;
  localparam logic [7:0] CmdR4  = 8'hE1;
  localparam logic [7:0] CmdR5  = 8'h66;
  localparam logic [7:0] CmdR6  = 8'h78;
  localparam logic [5:0] ReadSkip  = 6'd4;
  localparam logic [5:0] CrcSkip   = 6'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DEV,
    PH_REG,
    PH_DATA,
    PH_TRAIL
  } phase_t;

  phase_t     phase;
  logic [5:0] bytes_left;
  logic [7:0] cur_dev;
  logic [7:0] cur_reg;
  logic [7:0] dev_c_addr;
  logic [7:0] dev_d_addr;

  logic [5:0] wr_len;
  logic       is_rd;
  logic [5:0] left_dec;

  // Classify command byte
  always_comb begin
    unique case (item.bus_byte)
      CmdW1:   wr_len = 6'd1;
      CmdW2:   wr_len = 6'd2;
      CmdW3:   wr_len = 6'd3;
      CmdW4:   wr_len = 6'd4;
      CmdW12:  wr_len = 6'd12;
      CmdW16:  wr_len = 6'd16;
      CmdW32:  wr_len = 6'd32;
      default: wr_len = 6'd0;
    endcase
    is_rd = (item.bus_byte == CmdR0) || (item.bus_byte == CmdR1) ||
            (item.bus_byte == CmdR2) || (item.bus_byte == CmdR3) ||
            (item.bus_byte == CmdR4) || (item.bus_byte == CmdR5) ||
            (item.bus_byte == CmdR6);
    left_dec = bytes_left - 6'd1;
  end

  // Queue data bytes and frame ends
  assign push              = accept && ((phase == PH_DATA) || item.frame_end);
  assign push_op.is_data   = (phase == PH_DATA);
  assign push_op.hit_c     = (cur_dev == dev_c_addr);
  assign push_op.hit_d     = (cur_dev == dev_d_addr);
  assign push_op.register  = cur_reg;
  assign push_op.data      = item.bus_byte;
  assign push_op.frame_end = item.frame_end;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_c_addr <= DevCReset;
      dev_d_addr <= DevDReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEV_C: dev_c_addr <= cfg_wdata;
        CFG_DEV_D: dev_d_addr <= cfg_wdata;
        default:   dev_c_addr <= dev_c_addr;
      endcase
    end
  end

  // Walk command framing
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bytes_left <= '0;
      cur_dev    <= '0;
      cur_reg    <= '0;
    end else if (accept) begin
      // Drop any partial command at frame end
      if (item.frame_end) begin
        phase      <= PH_IDLE;
        bytes_left <= '0;
      end else begin
        unique case (phase)
          PH_IDLE: begin
            if (wr_len != 6'd0) begin
              bytes_left <= wr_len;
              phase      <= PH_DEV;
            end else if (is_rd) begin
              bytes_left <= ReadSkip;
              phase      <= PH_TRAIL;
            end
          end
          PH_DEV: begin
            cur_dev <= item.bus_byte;
            phase   <= PH_REG;
          end
          PH_REG: begin
            cur_reg <= item.bus_byte;
            phase   <= PH_DATA;
          end
          PH_DATA: begin
            cur_reg <= cur_reg + 8'd1;
            if (left_dec == 6'd0) begin
              bytes_left <= CrcSkip;
              phase      <= PH_TRAIL;
            end else begin
              bytes_left <= left_dec;
            end
          end
          default: begin
            bytes_left <= left_dec;
            if (left_dec == 6'd0) begin
              phase <= PH_IDLE;
            end
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/ulmwd_back.sv
// ----------------------------------------------------------------------------
// ulmwd_back
// Executes queued operations: saturating width accumulation for the twenty
// channels, snapshot and clear at frame end, and a two-stage duty pipeline
// (multiply, then divide by 1023) that issues one channel per beat.
// ----------------------------------------------------------------------------
module ulmwd_back
  import ulmwd_pkg::*;
#(
  parameter int SUM_WIDTH = SumWidthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  op_t       head_op,
  input  logic      empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int Pw = SUM_WIDTH + 14;
  localparam int Qw = Pw - 9;

  logic [SUM_WIDTH-1:0] sum      [NumCh];
  logic [SUM_WIDTH-1:0] sum_next [NumCh];
  logic [SUM_WIDTH-1:0] snap     [NumCh];

  logic           emitting;
  logic [ChW-1:0] idx;
  logic           adv;

  logic           p_valid;
  logic [Pw-1:0]  p_prod;
  logic [ChW-1:0] p_ch;
  logic           p_last;

  // Per-channel saturating add for the head operation
  for (genvar j = 0; j < NumCh; j++) begin : g_ch
    localparam int Top = (j < NumC) ? NumC - 1 : NumD - 1;
    localparam int Idx = (j < NumC) ? j : j - NumC;
    localparam int Grp = (Top - Idx) / 3;
    localparam int Pos = (Top - Idx) % 3;

    logic                hit;
    logic [9:0]          add;
    logic [SUM_WIDTH:0]  total;

    always_comb begin
      hit = head_op.is_data && ((j < NumC) ? head_op.hit_c : head_op.hit_d);
      add = '0;
      if (hit) begin
        if ((head_op.register >= 8'h30) && (head_op.register <= 8'h3B) &&
            (head_op.register[3:0] == 4'(Top - Idx))) begin
          add = {head_op.data, 2'b00};
        end else if ((head_op.register[7:2] == 6'h0F) &&
                     (head_op.register[1:0] == 2'(Grp))) begin
          add = {8'b0, head_op.data[2*Pos +: 2]};
        end
      end
      total       = {1'b0, sum[j]} + (SUM_WIDTH + 1)'(add);
      sum_next[j] = total[SUM_WIDTH] ? '1 : total[SUM_WIDTH-1:0];
    end
  end

  // Take an operation unless a frame end must wait for the snapshot bank
  assign pop = !empty && (!head_op.frame_end || !emitting);
  assign adv = !out_valid || out_ready;

  // Accumulate, snapshot and clear
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCh; i++) begin
        sum[i] <= '0;
      end
    end else if (pop) begin
      for (int i = 0; i < NumCh; i++) begin
        sum[i] <= head_op.frame_end ? '0 : sum_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_op.frame_end) begin
      for (int i = 0; i < NumCh; i++) begin
        snap[i] <= sum_next[i];
      end
    end
  end

  // Issue channels from the snapshot and scale
  always_ff @(posedge clk) begin
    if (rst) begin
      emitting <= 1'b0;
      idx      <= '0;
      p_valid  <= 1'b0;
    end else begin
      if (pop && head_op.frame_end) begin
        emitting <= 1'b1;
        idx      <= '0;
      end
      if (adv) begin
        p_valid <= emitting;
        if (emitting) begin
          idx <= idx + ChW'(1);
          if (idx == ChW'(NumCh - 1)) begin
            emitting <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emitting) begin
      p_prod <= Pw'(snap[idx]) * Pw'(DutyScale);
      p_ch   <= idx;
      p_last <= (idx == ChW'(NumCh - 1));
    end
  end

  // Divide by 1023 as 1024 - 1: two folds and a final correction
  logic [Qw-1:0] y;
  logic [11:0]   y2;
  logic [Qw-1:0] quo;
  logic [31:0]   quo_wide;
  logic [15:0]   duty;

  always_comb begin
    y        = Qw'(p_prod[Pw-1:10]) + Qw'(p_prod[9:0]);
    y2       = 12'(y[Qw-1:10]) + 12'(y[9:0]);
    quo      = Qw'(p_prod[Pw-1:10]) + Qw'(y[Qw-1:10]) +
               Qw'(y2 >= 12'd1023) + Qw'(y2 >= 12'd2046);
    quo_wide = 32'(quo);
    duty     = (quo_wide > 32'h0000_FFFF) ? 16'hFFFF : quo_wide[15:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p_valid) begin
      out_item.channel      <= 5'(p_ch);
      out_item.duty         <= duty;
      out_item.last_channel <= p_last;
    end
  end

endmodule

>>> tb/uart_led_matrix_write_decoder_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_led_matrix_write_decoder_unit_test
// Feeds captured bus bytes into the write decoder and scores every duty beat
// against an in-bench parser and accumulator model. Runs a directed frame and
// then random frames under several device address settings, with random
// idling on both channels and long output stalls to back up the input.
// ----------------------------------------------------------------------------
module uart_led_matrix_write_decoder_unit_test;
  import ulmwd_pkg::*;

  localparam int SumW          = SumWidthDefault;
  localparam int SumMax        = (1 << SumW) - 1;
  localparam int DutyDiv       = 1023;
  localparam int DrainCycles   = 16;
  localparam int LongHold      = 300;
  localparam int HoldEvery     = 120;
  localparam int HoldAt        = 50;
  localparam int WatchdogLimit = 4000;
  localparam int PhaseItems    = 56;

  // Bus command codes
  localparam logic [7:0] CMD_WR1  = 8'h87;
  localparam logic [7:0] CMD_WR2  = 8'h99;
  localparam logic [7:0] CMD_WR3  = 8'h1E;
  localparam logic [7:0] CMD_WR4  = 8'hAA;
  localparam logic [7:0] CMD_WR12 = 8'h2D;
  localparam logic [7:0] CMD_WR16 = 8'h33;
  localparam logic [7:0] CMD_WR32 = 8'hB4;
  localparam logic [7:0] CMD_RD_A = 8'h4B;
  localparam logic [7:0] CMD_RD_B = 8'hCC;
  localparam logic [7:0] CMD_RD_C = 8'hD2;
  localparam logic [7:0] CMD_RD_D = 8'h55;
  localparam logic [7:0] CMD_RD_E = 8'hE1;
  localparam logic [7:0] CMD_RD_F = 8'h66;
  localparam logic [7:0] CMD_RD_G = 8'h78;

  // Width register map
  localparam logic [7:0] REG_HI_FIRST = 8'h30;
  localparam logic [7:0] REG_HI_LAST  = 8'h3B;
  localparam logic [7:0] REG_LO_FIRST = 8'h3C;
  localparam logic [7:0] REG_LO_LAST  = 8'h3F;

  typedef enum logic [2:0] {
    PH_IDLE, PH_DEV, PH_REG, PH_DATA, PH_TRAIL
  } parse_phase_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_DEV_C;
  logic [7:0] cfg_wdata = 8'd0;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  in_item_t   byte_item = '0;
  logic       duty_valid;
  logic       duty_ready = 1'b0;
  out_item_t  duty_item;

  uart_led_matrix_write_decoder_unit #(
    .SUM_WIDTH(SumW)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item (byte_item),
    .duty_valid(duty_valid),
    .duty_ready(duty_ready),
    .duty_item (duty_item)
  );

  // Decoder model state
  logic [7:0]   dev_c_addr = DevCReset;
  logic [7:0]   dev_d_addr = DevDReset;
  parse_phase_t parse_phase = PH_IDLE;
  logic [5:0]   bytes_left = '0;
  logic [7:0]   cur_dev = '0;
  logic [7:0]   cur_reg = '0;
  int unsigned  width_c[NumC];
  int unsigned  width_d[NumD];

  // Stimulus and scoring
  in_item_t    byte_pending_q[$];
  out_item_t   duty_expect_q[$];
  out_item_t   duty_exp;
  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned beats_seen = 0;
  int unsigned fail_count = 0;
  int unsigned tx_gap_max = 9;
  int unsigned rx_gap_max = 9;
  int unsigned tx_gap = 0;
  int unsigned rx_hold = 0;
  int unsigned idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned write_len(logic [7:0] b);
    case (b)
      CMD_WR1:  return 1;
      CMD_WR2:  return 2;
      CMD_WR3:  return 3;
      CMD_WR4:  return 4;
      CMD_WR12: return 12;
      CMD_WR16: return 16;
      CMD_WR32: return 32;
      default:  return 0;
    endcase
  endfunction

  function automatic bit is_read_cmd(logic [7:0] b);
    return b == CMD_RD_A || b == CMD_RD_B || b == CMD_RD_C || b == CMD_RD_D ||
           b == CMD_RD_E || b == CMD_RD_F || b == CMD_RD_G;
  endfunction

  // Add to one accumulator, saturating; out-of-range channels are dropped
  function automatic void add_width(bit to_d, int idx, int unsigned v);
    int          count;
    int unsigned s;
    count = to_d ? NumD : NumC;
    if (idx < 0 || idx >= count) return;
    s = (to_d ? width_d[idx] : width_c[idx]) + v;
    if (s > SumMax) s = SumMax;
    if (to_d) width_d[idx] = s;
    else width_c[idx] = s;
  endfunction

  // Route one data byte of a width register into a channel bank
  function automatic void feed_widths(bit to_d, logic [7:0] regaddr, logic [7:0] data);
    int top;
    int ofs;
    int base;
    top = (to_d ? NumD : NumC) - 1;
    if (regaddr >= REG_HI_FIRST && regaddr <= REG_HI_LAST) begin
      ofs = int'(regaddr) - int'(REG_HI_FIRST);
      if (ofs <= top) add_width(to_d, top - ofs, int'(data) << 2);
    end else if (regaddr >= REG_LO_FIRST && regaddr <= REG_LO_LAST) begin
      base = top - 3 * (int'(regaddr) - int'(REG_LO_FIRST));
      add_width(to_d, base, int'(data[1:0]));
      add_width(to_d, base - 1, int'(data[3:2]));
      add_width(to_d, base - 2, int'(data[5:4]));
    end
  endfunction

  // Decode one accepted bus byte; queue the duty beats of a frame end
  function automatic void decode_byte(in_item_t it);
    int unsigned n;
    longint      d;
    out_item_t   r;
    logic [7:0]  b;
    b = it.bus_byte;
    case (parse_phase)
      PH_IDLE: begin
        n = write_len(b);
        if (n != 0) begin
          bytes_left = n[5:0];
          parse_phase = PH_DEV;
        end else if (is_read_cmd(b)) begin
          bytes_left = 6'd4;
          parse_phase = PH_TRAIL;
        end
      end
      PH_DEV: begin
        cur_dev = b;
        parse_phase = PH_REG;
      end
      PH_REG: begin
        cur_reg = b;
        parse_phase = PH_DATA;
      end
      PH_DATA: begin
        if (cur_dev == dev_c_addr) feed_widths(1'b0, cur_reg, b);
        if (cur_dev == dev_d_addr) feed_widths(1'b1, cur_reg, b);
        cur_reg = cur_reg + 8'd1;
        bytes_left = bytes_left - 6'd1;
        if (bytes_left == 0) begin
          bytes_left = 6'd2;
          parse_phase = PH_TRAIL;
        end
      end
      default: begin
        bytes_left = bytes_left - 6'd1;
        if (bytes_left == 0) parse_phase = PH_IDLE;
      end
    endcase
    if (it.frame_end) begin
      for (int k = 0; k < NumCh; k++) begin
        d = (k < NumC) ? longint'(width_c[k]) : longint'(width_d[k - NumC]);
        d = d * DutyScale / DutyDiv;
        if (d > 65535) d = 65535;
        r.channel = k[4:0];
        r.duty = d[15:0];
        r.last_channel = (k == NumCh - 1);
        duty_expect_q.push_back(r);
      end
      for (int k = 0; k < NumC; k++) width_c[k] = 0;
      for (int k = 0; k < NumD; k++) width_d[k] = 0;
      parse_phase = PH_IDLE;
      bytes_left = '0;
    end
  endfunction

  // Byte driver: hold until accepted, then idle a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (byte_valid && byte_ready) begin
        decode_byte(byte_item);
        bytes_accepted++;
        tx_gap = $urandom_range(0, tx_gap_max);
      end
      if (!(byte_valid && !byte_ready)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          byte_valid <= 1'b0;
        end else if (byte_pending_q.size() != 0) begin
          byte_item <= byte_pending_q.pop_front();
          byte_valid <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Duty monitor: score each beat, then stall a drawn or long stretch
  always @(posedge clk) begin
    if (rst) begin
      duty_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (duty_valid && duty_ready) begin
        if (duty_expect_q.size() == 0) begin
          $error("unexpected duty beat: channel %0d duty %0d", duty_item.channel,
                 duty_item.duty);
          fail_count++;
        end else begin
          duty_exp = duty_expect_q.pop_front();
          if (duty_item.channel !== duty_exp.channel) begin
            $error("channel: expected %0d, got %0d", duty_exp.channel, duty_item.channel);
            fail_count++;
          end
          if (duty_item.duty !== duty_exp.duty) begin
            $error("duty: expected %0d, got %0d", duty_exp.duty, duty_item.duty);
            fail_count++;
          end
          if (duty_item.last_channel !== duty_exp.last_channel) begin
            $error("last_channel: expected %0d, got %0d", duty_exp.last_channel,
                   duty_item.last_channel);
            fail_count++;
          end
        end
        beats_seen++;
        rx_hold = (beats_seen % HoldEvery == HoldAt) ? LongHold
                                                     : $urandom_range(0, rx_gap_max);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        duty_ready <= 1'b0;
      end else begin
        duty_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any beat or register write
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (duty_valid && duty_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic fe);
    byte_pending_q.push_back(in_item_t'({b, fe}));
    bytes_queued++;
  endtask

  task automatic cfg_write(cfg_index_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_DEV_C) dev_c_addr = val;
    else dev_d_addr = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every byte taken and every beat scored, then let the pipe settle
  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || duty_expect_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic [7:0] write_cmd(int unsigned i);
    case (i)
      0: return CMD_WR1;
      1: return CMD_WR2;
      2: return CMD_WR3;
      3: return CMD_WR4;
      4: return CMD_WR12;
      5: return CMD_WR16;
      6: return CMD_WR32;
      7: return CMD_WR1;
      default: return CMD_WR2;
    endcase
  endfunction

  function automatic logic [7:0] read_cmd(int unsigned i);
    case (i)
      0: return CMD_RD_A;
      1: return CMD_RD_B;
      2: return CMD_RD_C;
      3: return CMD_RD_D;
      4: return CMD_RD_E;
      5: return CMD_RD_F;
      default: return CMD_RD_G;
    endcase
  endfunction

  function automatic logic [7:0] pick_dev();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return dev_c_addr;
    if (sel < 8) return dev_d_addr;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly width registers, some near the wrap point, some anywhere
  function automatic logic [7:0] pick_reg();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return REG_HI_FIRST + 8'($urandom_range(0, 15));
    if (sel < 8) return 8'($urandom_range(8'hF0, 8'hFF));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_data();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return 8'hFF;
    if (sel < 3) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Build one frame of commands and queue it, frame end on its last byte
  task automatic gen_frame(int unsigned max_cmds);
    logic [7:0]  frame_q[$];
    logic [7:0]  code;
    logic [7:0]  dev;
    logic [7:0]  regaddr;
    int unsigned n_cmds;
    int unsigned sel;
    int unsigned len;
    n_cmds = $urandom_range(1, max_cmds);
    for (int i = 0; i < n_cmds; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        // well-formed write with trailer
        code = write_cmd($urandom_range(0, 9));
        len = write_len(code);
        frame_q.push_back(code);
        frame_q.push_back(pick_dev());
        frame_q.push_back(pick_reg());
        for (int j = 0; j < len; j++) frame_q.push_back(pick_data());
        frame_q.push_back(8'($urandom_range(0, 255)));
        frame_q.push_back(8'($urandom_range(0, 255)));
      end else if (sel < 75) begin
        frame_q.push_back(read_cmd($urandom_range(0, 6)));
        for (int j = 0; j < 4; j++) frame_q.push_back(8'($urandom_range(0, 255)));
      end else if (sel < 83) begin
        // hammer one high-byte register to drive it into saturation
        dev = pick_dev();
        regaddr = REG_HI_FIRST + 8'($urandom_range(0, 11));
        for (int j = 0; j < 6; j++) begin
          frame_q.push_back(CMD_WR1);
          frame_q.push_back(dev);
          frame_q.push_back(regaddr);
          frame_q.push_back(8'hFF);
          frame_q.push_back(8'($urandom_range(0, 255)));
          frame_q.push_back(8'($urandom_range(0, 255)));
        end
      end else if (sel < 92) begin
        frame_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        // write cut short; following bytes get absorbed as its payload
        code = write_cmd($urandom_range(0, 6));
        len = write_len(code);
        frame_q.push_back(code);
        frame_q.push_back(pick_dev());
        frame_q.push_back(pick_reg());
        len = $urandom_range(0, len - 1);
        for (int j = 0; j < len; j++) frame_q.push_back(pick_data());
      end
    end
    foreach (frame_q[j]) push_byte(frame_q[j], j == frame_q.size() - 1);
  endtask

  // Main sequence
  initial begin
    logic [7:0]  addr_c;
    logic [7:0]  addr_d;
    int unsigned stop_at;
    for (int k = 0; k < NumC; k++) width_c[k] = 0;
    for (int k = 0; k < NumD; k++) width_d[k] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frame under reset addresses: packed low bits on C, D high-byte
    // edge, a read that swallows a write, an unknown byte, and a frame end
    // that lands inside a write
    push_byte(CMD_WR4, 1'b0);
    push_byte(DevCReset, 1'b0);
    push_byte(REG_LO_FIRST, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(CMD_WR2, 1'b0);
    push_byte(DevDReset, 1'b0);
    push_byte(8'h37, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(CMD_RD_A, 1'b0);
    push_byte(CMD_WR1, 1'b0);
    push_byte(DevCReset, 1'b0);
    push_byte(REG_HI_FIRST, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(CMD_WR3, 1'b0);
    push_byte(DevCReset, 1'b0);
    push_byte(REG_HI_LAST, 1'b0);
    push_byte(8'hFF, 1'b1);
    wait_drained();

    // Random phases under different address settings and idling patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          addr_c = 8'h00;
          addr_d = 8'h00;
          tx_gap_max = 9;
          rx_gap_max = 9;
        end
        1: begin
          addr_c = 8'hFF;
          addr_d = 8'h00;
          tx_gap_max = 0;
          rx_gap_max = 0;
        end
        2: begin
          addr_c = 8'($urandom_range(0, 255));
          addr_d = 8'($urandom_range(0, 255));
          tx_gap_max = 9;
          rx_gap_max = 0;
        end
        default: begin
          addr_c = DevCReset;
          addr_d = DevDReset;
          tx_gap_max = 0;
          rx_gap_max = 9;
        end
      endcase
      cfg_write(CFG_DEV_C, addr_c);
      cfg_write(CFG_DEV_D, addr_d);
      @(negedge clk);
      stop_at = bytes_queued + PhaseItems;
      while (bytes_queued < stop_at) gen_frame(6);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ulmwd_pkg.sv
rtl/ulmwd_fifo.sv
rtl/ulmwd_front.sv
rtl/ulmwd_back.sv
rtl/uart_led_matrix_write_decoder_unit.sv
tb/uart_led_matrix_write_decoder_unit_test.sv
